[rtl/core/quaternion_divide_assert.svh]
// Assertion macros for the quaternion divider RTL.
// Depends on nothing; included by quaternion_divide, which checks its own logic.
`ifndef QUATERNION_DIVIDE_ASSERT_SVH
`define QUATERNION_DIVIDE_ASSERT_SVH
`ifndef SYNTHESIS
`define QD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("qdiv check failed");
`define QD_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("qdiv reset check failed");
`else
`define QD_ASSERT(lbl, clk, rst, prop)
`define QD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[rtl/core/qdiv_pkg.sv]
// Shared constants and types for the quaternion divider.
// No dependencies.
package qdiv_pkg;
   localparam int NCOMP = 4;
   // bit c*4+k set: term k of component c is subtracted; term k uses q[c ^ k]
   localparam logic [15:0] MINUS_MASK = 16'hAC60;

   typedef struct packed {
      logic [NCOMP-1:0] neg;
      logic [NCOMP-1:0] ovf;
      logic             zero;
   } qdiv_flags_type;
endpackage

[rtl/core/quaternion_divide.sv]
// Top level of the quaternion divider t = q / r; front, division chain, saturation.
// Depends on qdiv_pkg, qdiv_front, qdiv_step and quaternion_divide_assert.svh.
//
// Usage:
//   req channel carries one beat per quaternion pair: q_w, q_x, q_y, q_z, r_w, r_x,
//   r_y, r_z, each COMP_WIDTH bits signed with FRAC_BITS fraction bits.
//   rsp channel returns one beat per request: t_w..t_z in tdata, zero_divisor and
//   clipped in tuser. Quotients are truncated toward zero and saturated.
//   The pipeline has three front stages, one stage per quotient bit of the restoring
//   divider and one saturation stage.
//   Throughput is one beat per cycle while rsp is not stalled; every stage holds one beat.
//   The whole pipeline advances together: when rsp_tready is low and a result
//   waits, all stages hold and req_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; results in flight are dropped.
//   A zero divisor returns zeros with zero_divisor set and clipped clear.
module quaternion_divide #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 12,
   localparam int IN_W  = ((8*COMP_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((4*COMP_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // t_w, t_x, t_y, t_z
   output logic [OUT_W-1:0] rsp_tdata,
   // zero_divisor, clipped
   output logic [1:0]       rsp_tuser
);
   import qdiv_pkg::*;
   localparam int CW = COMP_WIDTH;
   localparam int RW = 2*CW + 1 + FRAC_BITS;

   logic                         en;
   logic [NCOMP-1:0][CW-1:0]     q, r;
   logic                         v_s [CW+1];
   logic [NCOMP-1:0][RW-1:0]     rem_s [CW+1];
   logic [2*CW:0]                norm_s [CW+1];
   logic [NCOMP-1:0][CW-1:0]     quo_s [CW+1];
   qdiv_flags_type               flags_s [CW+1];

   logic                         rsp_tvalid_ff;
   logic [OUT_W-1:0]             rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                   rsp_tuser_ff, rsp_tuser_in;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         q[c] = req_tdata[c*CW +: CW];
         r[c] = req_tdata[(c+NCOMP)*CW +: CW];
      end
   end

   qdiv_front #(.CW(CW), .FB(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .q         (q),
      .r         (r),
      .out_valid (v_s[0]),
      .out_rem   (rem_s[0]),
      .out_norm  (norm_s[0]),
      .out_flags (flags_s[0])
   );

   assign quo_s[0] = '0;

   for (genvar g = 0; g < CW; g++) begin : g_step
      qdiv_step #(.CW(CW), .FB(FRAC_BITS), .BIT(CW-1-g)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_s[g]),
         .in_rem    (rem_s[g]),
         .in_norm   (norm_s[g]),
         .in_quo    (quo_s[g]),
         .in_flags  (flags_s[g]),
         .out_valid (v_s[g+1]),
         .out_rem   (rem_s[g+1]),
         .out_norm  (norm_s[g+1]),
         .out_quo   (quo_s[g+1]),
         .out_flags (flags_s[g+1])
      );
   end

   always_comb begin
      logic [CW-1:0] lim;
      logic [CW-1:0] m;
      logic          over;
      logic          clip;
      qdiv_flags_type f;
      f    = flags_s[CW];
      clip = 1'b0;
      rsp_tdata_in = '0;
      for (int c = 0; c < NCOMP; c++) begin
         lim  = f.neg[c] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         over = f.ovf[c] || (quo_s[CW][c] > lim);
         m    = over ? lim : quo_s[CW][c];
         if (!f.zero) begin
            rsp_tdata_in[c*CW +: CW] = f.neg[c] ? CW'(~m + 1'b1) : m;
            clip = clip | over;
         end
      end
      rsp_tuser_in = {clip, f.zero};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= v_s[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`include "quaternion_divide_assert.svh"
   `QD_ASSERT(a_zero_result, clock, reset, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
   `QD_ASSERT(a_ready_follows_out, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   `QD_ASSERT_RST(a_reset_clears, clock, reset |=> !rsp_tvalid)
endmodule

[rtl/core/qdiv_front.sv]
// Front of the divider: products, signed sums and norm, magnitude and range check.
// Depends on qdiv_pkg.
module qdiv_front #(
   parameter int CW = 16,
   parameter int FB = 12,
   localparam int RW = 2*CW + 1 + FB
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [qdiv_pkg::NCOMP-1:0][CW-1:0]     q,
   input  logic [qdiv_pkg::NCOMP-1:0][CW-1:0]     r,
   output logic                                   out_valid,
   output logic [qdiv_pkg::NCOMP-1:0][RW-1:0]     out_rem,
   output logic [2*CW:0]                          out_norm,
   output qdiv_pkg::qdiv_flags_type               out_flags
);
   import qdiv_pkg::*;
   localparam int SW = 2*CW + 2;
   localparam int PW = 2*CW;

   logic                               v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]               prod_ff [NCOMP][NCOMP];
   logic signed [PW-1:0]               sq_ff [NCOMP];
   logic signed [SW-1:0]               num_ff [NCOMP];
   logic signed [SW-1:0]               num_in [NCOMP];
   logic [2*CW:0]                      norm2_ff, norm2_in, norm3_ff;
   logic [NCOMP-1:0][RW-1:0]           rem_ff, rem_in;
   qdiv_flags_type                     flags_ff, flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCOMP; k++) begin
            sq_ff[k] <= $signed(r[k]) * $signed(r[k]);
            for (int j = 0; j < NCOMP; j++) begin
               prod_ff[k][j] <= $signed(r[k]) * $signed(q[j]);
            end
         end
         num_ff   <= num_in;
         norm2_ff <= norm2_in;
         rem_ff   <= rem_in;
         norm3_ff <= norm2_ff;
         flags_ff <= flags_in;
      end
   end

   always_comb begin
      norm2_in = '0;
      for (int k = 0; k < NCOMP; k++) begin
         norm2_in = norm2_in + {1'b0, sq_ff[k]};
      end
      for (int c = 0; c < NCOMP; c++) begin
         num_in[c] = '0;
         for (int k = 0; k < NCOMP; k++) begin
            if (MINUS_MASK[c*NCOMP+k]) begin
               num_in[c] = num_in[c] - {{(SW-PW){prod_ff[k][c^k][PW-1]}}, prod_ff[k][c^k]};
            end else begin
               num_in[c] = num_in[c] + {{(SW-PW){prod_ff[k][c^k][PW-1]}}, prod_ff[k][c^k]};
            end
         end
      end
   end

   always_comb begin
      logic [SW-1:0]    mag;
      logic [RW+CW-1:0] lim;
      lim = {{(RW-2*CW-1){1'b0}}, norm2_ff, {CW{1'b0}}};
      flags_in.zero = (norm2_ff == '0);
      for (int c = 0; c < NCOMP; c++) begin
         flags_in.neg[c] = num_ff[c][SW-1];
         mag = num_ff[c][SW-1] ? SW'(-num_ff[c]) : SW'(num_ff[c]);
         rem_in[c] = {mag[SW-2:0], {FB{1'b0}}};
         flags_in.ovf[c] = ({{CW{1'b0}}, rem_in[c]} >= lim);
      end
   end

   assign out_valid = v3_ff;
   assign out_rem   = rem_ff;
   assign out_norm  = norm3_ff;
   assign out_flags = flags_ff;
endmodule

[rtl/core/qdiv_step.sv]
// One restoring division stage: resolves quotient bit BIT for all components.
// Depends on qdiv_pkg.
module qdiv_step #(
   parameter int CW  = 16,
   parameter int FB  = 12,
   parameter int BIT = 0,
   localparam int RW = 2*CW + 1 + FB
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [qdiv_pkg::NCOMP-1:0][RW-1:0]     in_rem,
   input  logic [2*CW:0]                          in_norm,
   input  logic [qdiv_pkg::NCOMP-1:0][CW-1:0]     in_quo,
   input  qdiv_pkg::qdiv_flags_type               in_flags,
   output logic                                   out_valid,
   output logic [qdiv_pkg::NCOMP-1:0][RW-1:0]     out_rem,
   output logic [2*CW:0]                          out_norm,
   output logic [qdiv_pkg::NCOMP-1:0][CW-1:0]     out_quo,
   output qdiv_pkg::qdiv_flags_type               out_flags
);
   import qdiv_pkg::*;
   localparam int XW = RW + CW;

   logic                          valid_ff;
   logic [NCOMP-1:0][RW-1:0]      rem_ff, rem_in;
   logic [NCOMP-1:0][CW-1:0]      quo_ff, quo_in;
   logic [2*CW:0]                 norm_ff;
   qdiv_flags_type                flags_ff;

   always_comb begin
      logic [XW-1:0] dsh;
      logic [XW-1:0] wide;
      dsh = {{(XW-2*CW-1){1'b0}}, in_norm} << BIT;
      for (int c = 0; c < NCOMP; c++) begin
         wide      = {{CW{1'b0}}, in_rem[c]};
         quo_in[c] = in_quo[c];
         rem_in[c] = in_rem[c];
         if (wide >= dsh) begin
            rem_in[c]      = RW'(wide - dsh);
            quo_in[c][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         norm_ff  <= in_norm;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_norm  = norm_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;
endmodule
